>>> rtl/core/tick_musical_time_converter_top_defines.svh
// Assertion macros for the tick/position converter.
`ifndef TICK_MUSICAL_TIME_CONVERTER_TOP_DEFINES_SVH
`define TICK_MUSICAL_TIME_CONVERTER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define TMC_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tmc assertion failed");
`define TMC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tmc assertion failed");
`else
`define TMC_ASSERT_NOW(lbl, ante, cons)
`define TMC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> rtl/core/tmc_pkg.sv
`timescale 1ns / 1ps
package tmc_pkg;
	localparam int unsigned MAP_DEPTH_DEF = 16;
	localparam int unsigned TICK_W     = 32;
	localparam int unsigned BAR_W      = 24;
	localparam int unsigned BEAT_IN_W  = 8;
	localparam int unsigned OFF_W      = 16;
	localparam int unsigned BEATS_W    = 6;
	localparam int unsigned UNIT_W     = 7;
	localparam int unsigned TPQ_W      = 10;
	localparam int unsigned ACT_W      = 5;
	localparam int unsigned KIND_W     = 2;
	localparam int unsigned IDX_W      = 4;
	localparam int unsigned STATUS_W   = 2;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 10;
	localparam int unsigned ENTRY_W    = TICK_W + BEATS_W + UNIT_W;
	// quarters per whole note as a shift
	localparam int unsigned QPW_SHIFT  = 2;
	localparam int unsigned LEN_W      = 18;
	localparam int unsigned SEG_TICK_W = 34;
	localparam int unsigned SEG_BAR_W  = 35;
	localparam int unsigned DIV_NUM_W  = 34;
	localparam int unsigned DIV_DEN_W  = LEN_W;
	localparam int unsigned MUL_A_W    = 34;
	localparam int unsigned PROD_W     = MUL_A_W + LEN_W;
	localparam int unsigned ACC_W      = 44;

	localparam logic [TPQ_W-1:0]   TPQ_RESET     = 10'd480;
	localparam logic [BEATS_W-1:0] DEFAULT_BEATS = 6'd4;

	typedef logic [KIND_W-1:0] kind_t;
	localparam kind_t KIND_LOAD = 2'd0;
	localparam kind_t KIND_T2P  = 2'd1;
	localparam kind_t KIND_P2T  = 2'd2;

	typedef logic [STATUS_W-1:0] status_t;
	localparam status_t ST_OK      = 2'd0;
	localparam status_t ST_INVALID = 2'd1;
	localparam status_t ST_SAT     = 2'd2;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_TPQ    = 2'd0;
	localparam cfg_idx_t CFG_ACTIVE = 2'd1;

	typedef struct packed {
		logic                 go;
		logic [DIV_NUM_W-1:0] num;
		logic [DIV_DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic                 done;
		logic [DIV_NUM_W-1:0] quot;
		logic [DIV_DEN_W-1:0] rem;
	} div_rsp_t;

	typedef enum logic [4:0] {
		S_IDLE, S_DISPATCH, S_NEXT, S_READ, S_DIV_N, S_MUL_N, S_CHECK,
		S_DIV_BAR, S_DIV_BEAT, S_FINAL, S_DIV_REM, S_DIV_POS, S_MUL_OFF,
		S_FIN_POS, S_MUL_BAR, S_MUL_BEAT, S_FIN_TICK
	} state_t;
endpackage

>>> rtl/core/tick_musical_time_converter_top.sv
// A load writes its map entry at dispatch and then raises done; a query walks the
// active map entries in order, each map step running up to three passes of the
// shared divider, then runs its final divide or multiply steps and raises done.
// Throughput: one item at a time; start is taken once busy falls.
// Reset clears control and configuration (480 ticks a quarter, no entries);
// the map holds no valid data until loaded. Results cannot be stalled.
`timescale 1ns / 1ps
`include "tick_musical_time_converter_top_defines.svh"
module tick_musical_time_converter_top #(
	parameter int unsigned MAP_DEPTH = tmc_pkg::MAP_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [tmc_pkg::KIND_W-1:0]        kind,
	input  logic [tmc_pkg::IDX_W-1:0]         entry_index,
	input  logic [tmc_pkg::TICK_W-1:0]        change_tick,
	input  logic [tmc_pkg::BEATS_W-1:0]       new_beats_per_bar,
	input  logic [tmc_pkg::UNIT_W-1:0]        new_beat_unit,
	input  logic [tmc_pkg::TICK_W-1:0]        target_tick,
	input  logic [tmc_pkg::BAR_W-1:0]         target_bar,
	input  logic [tmc_pkg::BEAT_IN_W-1:0]     target_beat,
	input  logic signed [tmc_pkg::OFF_W-1:0]  target_offset,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [tmc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [tmc_pkg::CFG_DATA_W-1:0]    cfg_data,
	output logic                              done,
	output logic [tmc_pkg::TICK_W-1:0]        out_tick,
	output logic [tmc_pkg::BAR_W-1:0]         out_bar,
	output logic [tmc_pkg::BEATS_W-1:0]       out_beat,
	output logic [tmc_pkg::OFF_W-1:0]         out_offset,
	output logic [tmc_pkg::STATUS_W-1:0]      status
);
	import tmc_pkg::*;

	localparam int unsigned AW = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
	localparam int unsigned CW = $clog2(MAP_DEPTH + 1);

	state_t state_q, state_d;

	logic [TPQ_W-1:0] tpq_q;
	logic [ACT_W-1:0] active_q;
	logic [TPQ_W-1:0] tpq_eff;
	logic [CW-1:0]    ent_count;
	logic [CW-1:0]    ent_idx_q;
	logic             done_q;

	// latched item
	kind_t                 kind_q;
	logic [IDX_W-1:0]      idx_q;
	logic [TICK_W-1:0]     ctick_q;
	logic [BEATS_W-1:0]    nbeats_q;
	logic [UNIT_W-1:0]     nunit_q;
	logic [TICK_W-1:0]     target_q;
	logic [BAR_W-1:0]      tbar_q;
	logic [BEAT_IN_W-1:0]  tbeat_q;
	logic [OFF_W-1:0]      toff_q;

	// current segment
	logic [SEG_TICK_W-1:0] seg_tick_q;
	logic [SEG_BAR_W-1:0]  seg_bar_q;
	logic [LEN_W-1:0]      bar_len_q;
	logic [LEN_W-1:0]      beat_len_q;
	logic [BEATS_W-1:0]    beats_q;

	// entry under inspection
	logic [BEATS_W-1:0]    e_beats_q;
	logic [UNIT_W-1:0]     e_unit_q;
	logic [DIV_NUM_W-1:0]  n_q;
	logic [PROD_W-1:0]     prod_q;
	logic [ACC_W-1:0]      acc_q;
	logic [LEN_W-1:0]      rem_q;
	logic [SEG_BAR_W:0]    bar_res_q;
	logic [BEATS_W-1:0]    beat_q;

	// results
	logic [TICK_W-1:0]     res_tick_q;
	logic [BAR_W-1:0]      res_bar_q;
	logic [BEATS_W-1:0]    res_beat_q;
	logic [OFF_W-1:0]      res_off_q;
	status_t               res_status_q;

	logic                  ram_we, ram_re;
	logic [ENTRY_W-1:0]    ram_wdata, ram_rdata;
	logic [TICK_W-1:0]     rd_tick;
	logic [BEATS_W-1:0]    rd_beats;
	logic [UNIT_W-1:0]     rd_unit;

	div_req_t              div_req;
	div_rsp_t              div_rsp;

	logic                  mul_en;
	logic [MUL_A_W-1:0]    mul_a;
	logic [LEN_W-1:0]      mul_b;

	logic                  idx_ok, pos_bad, stop;
	logic [SEG_TICK_W-1:0] rd_tick_ext, ceil_num, a_val;
	logic [SEG_BAR_W:0]    bar_after;
	logic [LEN_W-1:0]      bar_num, bar_new, beat_new;
	logic [LEN_W-1:0]      off_full;
	logic [ACC_W-1:0]      tick_sum;

	assign tpq_eff   = (tpq_q == '0) ? TPQ_W'(1) : tpq_q;
	assign ent_count = (32'(active_q) > MAP_DEPTH) ? CW'(MAP_DEPTH) : CW'(active_q);
	assign idx_ok    = 32'(idx_q) < MAP_DEPTH;
	assign pos_bad   = (tbar_q == '0) || (tbeat_q == '0) || toff_q[OFF_W-1];

	assign ram_wdata = {ctick_q, nbeats_q, nunit_q};
	assign {rd_tick, rd_beats, rd_unit} = ram_rdata;
	assign rd_tick_ext = SEG_TICK_W'(rd_tick);
	assign ceil_num  = rd_tick_ext - seg_tick_q + SEG_TICK_W'(bar_len_q) - SEG_TICK_W'(1);
	assign a_val     = seg_tick_q + SEG_TICK_W'(prod_q);
	assign bar_after = (SEG_BAR_W+1)'(seg_bar_q) + (SEG_BAR_W+1)'(n_q);
	assign stop      = (kind_q == KIND_T2P) ? (SEG_TICK_W'(target_q) < a_val)
	                                        : ((SEG_BAR_W+1)'(tbar_q) < bar_after);
	assign bar_num   = LEN_W'((LEN_W'(e_beats_q) * LEN_W'(tpq_eff)) << QPW_SHIFT);
	assign bar_new   = (div_rsp.quot[LEN_W-1:0] == '0) ? LEN_W'(1) : div_rsp.quot[LEN_W-1:0];
	assign beat_new  = bar_new;
	assign off_full  = rem_q - prod_q[LEN_W-1:0];
	assign tick_sum  = acc_q + ACC_W'(prod_q) + ACC_W'(toff_q[OFF_W-2:0]);

	tmc_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(MAP_DEPTH),
		.AW   (AW)
	) u_map (
		.clk  (clk),
		.we   (ram_we),
		.waddr(AW'(idx_q)),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ent_idx_q[AW-1:0]),
		.rdata(ram_rdata)
	);

	tmc_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		div_req = '0;
		ram_we  = 1'b0;
		ram_re  = 1'b0;
		mul_en  = 1'b0;
		mul_a   = '0;
		mul_b   = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				unique case (kind_q)
					KIND_LOAD: begin
						ram_we  = idx_ok;
						state_d = S_IDLE;
					end
					KIND_T2P: state_d = S_NEXT;
					KIND_P2T: state_d = pos_bad ? S_IDLE : S_NEXT;
					default:  state_d = S_IDLE;
				endcase
			end
			S_NEXT: begin
				if (ent_idx_q == ent_count) begin
					state_d = S_FINAL;
				end else begin
					ram_re  = 1'b1;
					state_d = S_READ;
				end
			end
			S_READ: begin
				if (rd_beats == '0 || rd_unit == '0) begin
					state_d = S_NEXT;
				end else if (rd_tick_ext <= seg_tick_q) begin
					state_d = S_CHECK;
				end else begin
					div_req = '{go: 1'b1, num: DIV_NUM_W'(ceil_num), den: bar_len_q};
					state_d = S_DIV_N;
				end
			end
			S_DIV_N: begin
				if (div_rsp.done) begin
					state_d = S_MUL_N;
				end
			end
			S_MUL_N: begin
				mul_en  = 1'b1;
				mul_a   = MUL_A_W'(n_q);
				mul_b   = bar_len_q;
				state_d = S_CHECK;
			end
			S_CHECK: begin
				if (stop) begin
					state_d = S_FINAL;
				end else begin
					div_req = '{go: 1'b1, num: DIV_NUM_W'(bar_num),
						den: DIV_DEN_W'(e_unit_q)};
					state_d = S_DIV_BAR;
				end
			end
			S_DIV_BAR: begin
				if (div_rsp.done) begin
					div_req = '{go: 1'b1, num: DIV_NUM_W'(bar_new),
						den: DIV_DEN_W'(beats_q)};
					state_d = S_DIV_BEAT;
				end
			end
			S_DIV_BEAT: begin
				if (div_rsp.done) begin
					state_d = S_NEXT;
				end
			end
			S_FINAL: begin
				if (kind_q == KIND_T2P) begin
					div_req = '{go: 1'b1,
						num: DIV_NUM_W'(SEG_TICK_W'(target_q) - seg_tick_q),
						den: bar_len_q};
					state_d = S_DIV_REM;
				end else begin
					state_d = S_MUL_BAR;
				end
			end
			S_DIV_REM: begin
				if (div_rsp.done) begin
					div_req = '{go: 1'b1, num: DIV_NUM_W'(div_rsp.rem), den: beat_len_q};
					state_d = S_DIV_POS;
				end
			end
			S_DIV_POS: begin
				if (div_rsp.done) begin
					state_d = S_MUL_OFF;
				end
			end
			S_MUL_OFF: begin
				mul_en  = 1'b1;
				mul_a   = MUL_A_W'(beat_q);
				mul_b   = beat_len_q;
				state_d = S_FIN_POS;
			end
			S_FIN_POS: state_d = S_IDLE;
			S_MUL_BAR: begin
				mul_en  = 1'b1;
				mul_a   = MUL_A_W'(tbar_q - seg_bar_q[BAR_W-1:0]);
				mul_b   = bar_len_q;
				state_d = S_MUL_BEAT;
			end
			S_MUL_BEAT: begin
				mul_en  = 1'b1;
				mul_a   = MUL_A_W'(tbeat_q - BEAT_IN_W'(1));
				mul_b   = beat_len_q;
				state_d = S_FIN_TICK;
			end
			S_FIN_TICK: state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	// control and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tpq_q     <= TPQ_RESET;
			active_q  <= '0;
			done_q    <= 1'b0;
			ent_idx_q <= '0;
		end else begin
			done_q <= (state_q != S_IDLE) && (state_d == S_IDLE);
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_TPQ:    tpq_q    <= cfg_data[TPQ_W-1:0];
					CFG_ACTIVE: active_q <= cfg_data[ACT_W-1:0];
					default:    ;
				endcase
			end
			if (state_q == S_DISPATCH) begin
				ent_idx_q <= '0;
			end else if ((state_q == S_READ && (rd_beats == '0 || rd_unit == '0)) ||
			             (state_q == S_DIV_BEAT && div_rsp.done)) begin
				ent_idx_q <= ent_idx_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mul_en) begin
			prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
		end
		case (state_q)
			S_IDLE: begin
				if (start) begin
					kind_q   <= kind;
					idx_q    <= entry_index;
					ctick_q  <= change_tick;
					nbeats_q <= new_beats_per_bar;
					nunit_q  <= new_beat_unit;
					target_q <= target_tick;
					tbar_q   <= target_bar;
					tbeat_q  <= target_beat;
					toff_q   <= target_offset;
				end
			end
			S_DISPATCH: begin
				// default 4/4 segment from tick 0, bar 1
				seg_tick_q   <= '0;
				seg_bar_q    <= SEG_BAR_W'(1);
				bar_len_q    <= LEN_W'(tpq_eff) << QPW_SHIFT;
				beat_len_q   <= LEN_W'(tpq_eff);
				beats_q      <= DEFAULT_BEATS;
				res_tick_q   <= '0;
				res_bar_q    <= '0;
				res_beat_q   <= '0;
				res_off_q    <= '0;
				res_status_q <= (kind_q == KIND_LOAD) ? ST_OK : ST_INVALID;
			end
			S_READ: begin
				e_beats_q <= rd_beats;
				e_unit_q  <= rd_unit;
				n_q       <= '0;
				prod_q    <= '0;
			end
			S_DIV_N: begin
				if (div_rsp.done) begin
					n_q <= div_rsp.quot;
				end
			end
			S_CHECK: begin
				if (!stop) begin
					seg_tick_q <= a_val;
					seg_bar_q  <= bar_after[SEG_BAR_W-1:0];
					beats_q    <= e_beats_q;
				end
			end
			S_DIV_BAR: begin
				if (div_rsp.done) begin
					bar_len_q <= bar_new;
				end
			end
			S_DIV_BEAT: begin
				if (div_rsp.done) begin
					beat_len_q <= beat_new;
				end
			end
			S_DIV_REM: begin
				if (div_rsp.done) begin
					bar_res_q <= (SEG_BAR_W+1)'(seg_bar_q) + (SEG_BAR_W+1)'(div_rsp.quot);
					rem_q     <= div_rsp.rem;
				end
			end
			S_DIV_POS: begin
				if (div_rsp.done) begin
					// last beat absorbs the slack of the bar
					if (div_rsp.quot > DIV_NUM_W'(beats_q - BEATS_W'(1))) begin
						beat_q <= beats_q - BEATS_W'(1);
					end else begin
						beat_q <= div_rsp.quot[BEATS_W-1:0];
					end
				end
			end
			S_FIN_POS: begin
				res_tick_q   <= '0;
				res_beat_q   <= beat_q + BEATS_W'(1);
				res_status_q <= ST_OK;
				if (|bar_res_q[SEG_BAR_W:BAR_W]) begin
					res_bar_q    <= '1;
					res_status_q <= ST_SAT;
				end else begin
					res_bar_q <= bar_res_q[BAR_W-1:0];
				end
				if (|off_full[LEN_W-1:OFF_W]) begin
					res_off_q    <= '1;
					res_status_q <= ST_SAT;
				end else begin
					res_off_q <= off_full[OFF_W-1:0];
				end
			end
			S_MUL_BEAT: begin
				acc_q <= ACC_W'(seg_tick_q) + ACC_W'(prod_q);
			end
			S_FIN_TICK: begin
				res_bar_q  <= '0;
				res_beat_q <= '0;
				res_off_q  <= '0;
				if (|tick_sum[ACC_W-1:TICK_W]) begin
					res_tick_q   <= '1;
					res_status_q <= ST_SAT;
				end else begin
					res_tick_q   <= tick_sum[TICK_W-1:0];
					res_status_q <= ST_OK;
				end
			end
			default: ;
		endcase
	end

	assign busy       = (state_q != S_IDLE);
	// take configuration only while no item is in flight
	assign cfg_ready  = !busy;
	assign done       = done_q;
	assign out_tick   = res_tick_q;
	assign out_bar    = res_bar_q;
	assign out_beat   = res_beat_q;
	assign out_offset = res_off_q;
	assign status     = res_status_q;

	`TMC_ASSERT_NEXT(a_accept_goes_busy, start && !busy, busy)
	`TMC_ASSERT_NOW(a_done_after_work, done, $past(busy))
	`TMC_ASSERT_NOW(a_one_result_kind, done, out_tick == '0 || out_bar == '0)
endmodule

>>> rtl/core/tmc_ram.sv
`timescale 1ns / 1ps
module tmc_ram #(
	parameter int unsigned WIDTH = tmc_pkg::ENTRY_W,
	parameter int unsigned DEPTH = tmc_pkg::MAP_DEPTH_DEF,
	parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

>>> rtl/core/tmc_div.sv
`timescale 1ns / 1ps
module tmc_div (
	input  logic              clk,
	input  logic              arst_n,
	input  tmc_pkg::div_req_t req,
	output tmc_pkg::div_rsp_t rsp
);
	import tmc_pkg::*;

	localparam int unsigned CNT_W = $clog2(DIV_NUM_W + 1);

	logic [CNT_W-1:0]     cnt_q;
	logic                 done_q;
	logic [DIV_NUM_W-1:0] quo_q;
	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_DEN_W:0]   trial;
	logic                 fits;

	// restoring division, one quotient bit a cycle
	assign trial = {rem_q, quo_q[DIV_NUM_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CNT_W'(1));
			if (req.go) begin
				cnt_q <= CNT_W'(DIV_NUM_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			quo_q <= req.num;
			rem_q <= '0;
			den_q <= req.den;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? DIV_DEN_W'(trial - {1'b0, den_q}) : trial[DIV_DEN_W-1:0];
			quo_q <= {quo_q[DIV_NUM_W-2:0], fits};
		end
	end

	assign rsp = '{done: done_q, quot: quo_q, rem: rem_q};
endmodule

>>> tb/sv/tmc_checker.sv
`timescale 1ns / 1ps
module tmc_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic                              busy,
	input  logic [tmc_pkg::KIND_W-1:0]        kind,
	input  logic [tmc_pkg::IDX_W-1:0]         entry_index,
	input  logic [tmc_pkg::TICK_W-1:0]        change_tick,
	input  logic [tmc_pkg::BEATS_W-1:0]       new_beats_per_bar,
	input  logic [tmc_pkg::UNIT_W-1:0]        new_beat_unit,
	input  logic [tmc_pkg::TICK_W-1:0]        target_tick,
	input  logic [tmc_pkg::BAR_W-1:0]         target_bar,
	input  logic [tmc_pkg::BEAT_IN_W-1:0]     target_beat,
	input  logic signed [tmc_pkg::OFF_W-1:0]  target_offset,
	input  logic                              cfg_valid,
	input  logic                              cfg_ready,
	input  logic [tmc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [tmc_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              done,
	input  logic [tmc_pkg::TICK_W-1:0]        out_tick,
	input  logic [tmc_pkg::BAR_W-1:0]         out_bar,
	input  logic [tmc_pkg::BEATS_W-1:0]       out_beat,
	input  logic [tmc_pkg::OFF_W-1:0]         out_offset,
	input  logic [tmc_pkg::STATUS_W-1:0]      status,
	output int                                fails,
	output int                                pending
);
	import tmc_pkg::*;

	localparam int DEPTH = 16;

	typedef longint unsigned u64;

	typedef struct {
		u64 st_tick;
		u64 st_bar;
		u64 bar_len;
		u64 beat_len;
		u64 beats;
	} span_t;

	typedef struct packed {
		logic [TICK_W-1:0]   tick;
		logic [BAR_W-1:0]    bar;
		logic [BEATS_W-1:0]  beat;
		logic [OFF_W-1:0]    offset;
		status_t             st;
	} position_t;

	logic [TICK_W-1:0]  sig_tick [DEPTH];
	logic [BEATS_W-1:0] sig_beats [DEPTH];
	logic [UNIT_W-1:0]  sig_unit [DEPTH];
	logic [TPQ_W-1:0]   tpq;
	logic [ACT_W-1:0]   active;
	position_t          expected_q [$];

	function automatic span_t with_signature(span_t s, u64 beats, u64 unit);
		u64 res;
		u64 bar;
		res = (tpq == 0) ? 1 : u64'(tpq);
		bar = beats * res * 4 / unit;
		if (bar < 1) bar = 1;
		s.bar_len = bar;
		s.beat_len = bar / beats;
		if (s.beat_len < 1) s.beat_len = 1;
		s.beats = beats;
		return s;
	endfunction

	// next bar start at or after t, never before the span start
	function automatic u64 bar_start_from(span_t s, u64 t);
		if (t <= s.st_tick) return s.st_tick;
		return s.st_tick + ((t - s.st_tick + s.bar_len - 1) / s.bar_len) * s.bar_len;
	endfunction

	function automatic position_t convert(kind_t k, logic [TICK_W-1:0] ttick,
			logic [BAR_W-1:0] tbar, logic [BEAT_IN_W-1:0] tbeat, logic [OFF_W-1:0] toff);
		position_t r;
		span_t s;
		int n;
		u64 a, rem, bar, beat, off, tick;
		r = '0;
		n = (active > DEPTH) ? DEPTH : int'(active);
		s.st_tick = 0;
		s.st_bar = 1;
		s = with_signature(s, u64'(4), u64'(4));
		if (k == KIND_T2P) begin
			for (int i = 0; i < n; i++) begin
				if (sig_beats[i] == 0 || sig_unit[i] == 0) continue;
				a = bar_start_from(s, u64'(sig_tick[i]));
				if (u64'(ttick) < a) break;
				s.st_bar += (a - s.st_tick) / s.bar_len;
				s.st_tick = a;
				s = with_signature(s, u64'(sig_beats[i]), u64'(sig_unit[i]));
			end
			rem = u64'(ttick) - s.st_tick;
			bar = s.st_bar + rem / s.bar_len;
			rem = rem % s.bar_len;
			beat = rem / s.beat_len;
			if (beat > s.beats - 1) beat = s.beats - 1;
			off = rem - beat * s.beat_len;
			if (bar > 64'hFFFFFF) begin
				bar = 64'hFFFFFF;
				r.st = ST_SAT;
			end
			if (off > 64'hFFFF) begin
				off = 64'hFFFF;
				r.st = ST_SAT;
			end
			r.bar = bar[BAR_W-1:0];
			r.beat = BEATS_W'(beat + 1);
			r.offset = off[OFF_W-1:0];
		end else if (k == KIND_P2T) begin
			if (tbar == 0 || tbeat == 0 || toff[OFF_W-1]) begin
				r.st = ST_INVALID;
				return r;
			end
			for (int i = 0; i < n; i++) begin
				if (sig_beats[i] == 0 || sig_unit[i] == 0) continue;
				a = bar_start_from(s, u64'(sig_tick[i]));
				if (u64'(tbar) < s.st_bar + (a - s.st_tick) / s.bar_len) break;
				s.st_bar += (a - s.st_tick) / s.bar_len;
				s.st_tick = a;
				s = with_signature(s, u64'(sig_beats[i]), u64'(sig_unit[i]));
			end
			tick = s.st_tick + (u64'(tbar) - s.st_bar) * s.bar_len
				+ (u64'(tbeat) - 1) * s.beat_len + u64'(toff);
			if (tick > 64'hFFFFFFFF) begin
				r.tick = '1;
				r.st = ST_SAT;
			end else begin
				r.tick = tick[TICK_W-1:0];
			end
		end else if (k != KIND_LOAD) begin
			r.st = ST_INVALID;
		end
		return r;
	endfunction

	function automatic void compare_field(string name, u64 want, u64 got);
		if (want != got) begin
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
			fails++;
		end
	endfunction

	assign pending = expected_q.size();

	always @(posedge clk or negedge arst_n) begin
		position_t want;
		if (!arst_n) begin
			tpq <= TPQ_RESET;
			active <= '0;
			fails = 0;
			expected_q.delete();
		end else begin
			if (done) begin
				if (expected_q.size() == 0) begin
					$display("%0t: result word with nothing expected", $time);
					fails++;
				end else begin
					want = expected_q.pop_front();
					compare_field("out_tick", u64'(want.tick), u64'(out_tick));
					compare_field("out_bar", u64'(want.bar), u64'(out_bar));
					compare_field("out_beat", u64'(want.beat), u64'(out_beat));
					compare_field("out_offset", u64'(want.offset), u64'(out_offset));
					compare_field("status", u64'(want.st), u64'(status));
				end
			end
			if (start && !busy) begin
				expected_q = {expected_q, convert(kind, target_tick, target_bar,
					target_beat, target_offset)};
				if (kind == KIND_LOAD) begin
					sig_tick[entry_index] <= change_tick;
					sig_beats[entry_index] <= new_beats_per_bar;
					sig_unit[entry_index] <= new_beat_unit;
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_TPQ) tpq <= cfg_data[TPQ_W-1:0];
				else if (cfg_index == CFG_ACTIVE) active <= cfg_data[ACT_W-1:0];
			end
		end
	end
endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
	import tmc_pkg::*;

	localparam int RANDOM_WORDS = 1600;
	// kind code with no operation behind it
	localparam kind_t KIND_BAD = 2'd3;

	logic                  clk = 0;
	logic                  arst_n = 0;
	logic                  start = 0;
	logic                  busy;
	logic [KIND_W-1:0]     kind = '0;
	logic [IDX_W-1:0]      entry_index = '0;
	logic [TICK_W-1:0]     change_tick = '0;
	logic [BEATS_W-1:0]    new_beats_per_bar = '0;
	logic [UNIT_W-1:0]     new_beat_unit = '0;
	logic [TICK_W-1:0]     target_tick = '0;
	logic [BAR_W-1:0]      target_bar = '0;
	logic [BEAT_IN_W-1:0]  target_beat = '0;
	logic signed [OFF_W-1:0] target_offset = '0;
	logic                  cfg_valid = 0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  done;
	logic [TICK_W-1:0]     out_tick;
	logic [BAR_W-1:0]      out_bar;
	logic [BEATS_W-1:0]    out_beat;
	logic [OFF_W-1:0]      out_offset;
	logic [STATUS_W-1:0]   status;
	int                    fails;
	int                    pending;
	logic [TICK_W-1:0]     loaded_tick [16];

	always #5 clk = ~clk;

	tick_musical_time_converter_top dut (.*);

	tmc_checker checker_i (.*);

	task automatic send_word(kind_t k, logic [3:0] idx, logic [31:0] ctick,
			logic [5:0] beats, logic [6:0] unit, logic [31:0] ttick, logic [23:0] tbar,
			logic [7:0] tbeat, logic [15:0] toff);
		int gap;
		gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
		@(negedge clk);
		kind <= k;
		entry_index <= idx;
		change_tick <= ctick;
		new_beats_per_bar <= beats;
		new_beat_unit <= unit;
		target_tick <= ttick;
		target_bar <= tbar;
		target_beat <= tbeat;
		target_offset <= toff;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		if (k == KIND_LOAD) loaded_tick[idx] = ctick;
		if (gap > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// hold until every expected word is back and the block is quiet
	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (pending != 0 || busy) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
		drain();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic load_random(bit tidy);
		logic [3:0] idx;
		logic [31:0] ctick;
		logic [5:0] beats;
		logic [6:0] unit;
		idx = 4'($urandom_range(0, 15));
		ctick = tidy ? idx * $urandom_range(0, 20000) + $urandom_range(0, 50) : $urandom();
		beats = tidy ? 6'($urandom_range(1, 32)) : 6'($urandom_range(0, 63));
		unit = tidy ? 7'(1 << $urandom_range(0, 6)) : 7'($urandom_range(0, 127));
		if ($urandom_range(0, 3) == 0 && tidy) unit = 7'($urandom_range(1, 64));
		send_word(KIND_LOAD, idx, ctick, beats, unit, $urandom(), 24'($urandom()),
			8'($urandom()), 16'($urandom()));
	endtask

	task automatic query_tick();
		logic [31:0] t;
		case ($urandom_range(0, 4))
			0, 1: t = $urandom_range(0, 400000);
			2: t = $urandom();
			default: t = loaded_tick[$urandom_range(0, 15)] + $urandom_range(0, 64) - 32;
		endcase
		send_word(KIND_T2P, 4'($urandom()), $urandom(), 6'($urandom()), 7'($urandom()), t,
			24'($urandom()), 8'($urandom()), 16'($urandom()));
	endtask

	task automatic query_position();
		logic [23:0] b;
		logic [7:0] bt;
		logic [15:0] o;
		case ($urandom_range(0, 6))
			0: b = 24'($urandom_range(0, 3));
			1: b = 24'($urandom());
			default: b = 24'($urandom_range(1, 300));
		endcase
		bt = $urandom_range(0, 4) < 3 ? 8'($urandom_range(1, 8)) : 8'($urandom_range(0, 255));
		o = $urandom_range(0, 4) < 4 ? 16'($urandom_range(0, 2000))
			: 16'($urandom_range(0, 65535));
		send_word(KIND_P2T, 4'($urandom()), $urandom(), 6'($urandom()), 7'($urandom()),
			$urandom(), b, bt, o);
	endtask

	initial begin
		logic [9:0] res;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// tidy map, with one entry of zero beats and one of zero unit
		for (int i = 0; i < 16; i++)
			send_word(KIND_LOAD, 4'(i), 32'(i * 2880 + (i % 3) * 7),
				i == 5 ? 6'd0 : 6'(i % 7 + 2), i == 9 ? 7'd0 : 7'(1 << (i % 4)),
				'0, '0, '0, '0);
		write_reg(CFG_ACTIVE, 10'd16);
		send_word(KIND_T2P, '0, '0, '0, '0, 32'd0, '0, '0, '0);
		send_word(KIND_T2P, '0, '0, '0, '0, 32'hFFFF_FFFF, '0, '0, '0);
		send_word(KIND_P2T, '0, '0, '0, '0, '0, 24'd0, 8'd1, 16'd0);
		send_word(KIND_P2T, '0, '0, '0, '0, '0, 24'd3, 8'd0, 16'd0);
		send_word(KIND_P2T, '0, '0, '0, '0, '0, 24'd3, 8'd2, 16'h8000);
		send_word(KIND_P2T, '0, '0, '0, '0, '0, 24'hFFFFFF, 8'd255, 16'h7FFF);
		send_word(KIND_P2T, '0, '0, '0, '0, '0, 24'd1, 8'd1, 16'hFFFF);
		send_word(KIND_BAD, 4'hF, '1, '1, '1, '1, '1, '1, '1);

		for (int n = 0; n < RANDOM_WORDS; n++) begin
			if (n % 150 == 0) begin
				case ($urandom_range(0, 5))
					0: res = 10'd0;
					1: res = 10'd1;
					2: res = 10'd960;
					3: res = 10'h3FF;
					4: res = 10'd480;
					default: res = 10'($urandom_range(1, 960));
				endcase
				write_reg(CFG_TPQ, res);
				write_reg(CFG_ACTIVE, $urandom_range(0, 3) == 0 ? 10'($urandom_range(0, 31))
					: 10'($urandom_range(0, 16)));
			end
			case ($urandom_range(0, 19))
				0, 1: load_random(1'b1);
				2: load_random(1'b0);
				3: send_word(KIND_BAD, 4'($urandom()), $urandom(), 6'($urandom()),
					7'($urandom()), $urandom(), 24'($urandom()), 8'($urandom()),
					16'($urandom()));
				4, 5, 6, 7, 8, 9, 10, 11: query_tick();
				default: query_position();
			endcase
		end

		drain();
		repeat (2500) @(posedge clk);
		if (fails == 0) $display("Test completed successfully");
		else $display("Test completed with failures");
		$finish;
	end

	initial begin
		#300ms;
		$display("Test completed with failures");
		$finish;
	end
endmodule
